// ----- src/fptb_pkg.sv -----
// Shared constants and types for the Fermat probable-prime tester.
package fptb_pkg;

  localparam int unsigned VALUE_BITS_DEF = 63;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture candidate, set up base 2
    logic next_base;  // set up base 3 after base 2 finishes
    logic mul_start;  // start a modular multiply
    logic mul_sq;     // 1: square, 0: acc * sq
    logic mul_step;   // one shift-add step
    logic mul_store;  // write product back
    logic exp_shift;  // shift exponent right
    logic keep_r2;    // latch verdict of base 2
  } fptb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
    logic small_n;  // candidate is 0 or 1
    logic verdict;
  } fptb_sts_t;

endpackage

// ----- src/fptb_datapath.sv -----
// Datapath: candidate, exponent, residues and a shift-add modular multiplier.
module fptb_datapath import fptb_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [62:0]           candidate_i,
  input  fptb_cmd_t             cmd_i,
  output fptb_sts_t             sts_o
);

  localparam int unsigned CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] n_q, e_q, acc_q, sq_q, pa_q, pb_q, pr_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q, r2ok_q;
  logic [VALUE_BITS:0]   dbl, sum;
  logic [VALUE_BITS-1:0] dbl_r, sum_r, n_in, b2, b3, one;

  assign n_in = candidate_i[VALUE_BITS-1:0];
  // Bases reduced modulo n; n > 3 keeps them, n == 2 or 3 reduces, else unused
  assign one  = VALUE_BITS'(1);
  assign b2   = (n_in == VALUE_BITS'(2)) ? '0 : VALUE_BITS'(2);
  always_comb begin
    b3 = VALUE_BITS'(3);
    if (n_q == VALUE_BITS'(2)) begin
      b3 = one;
    end else if (n_q == VALUE_BITS'(3)) begin
      b3 = '0;
    end
  end

  // One shift-add step: double, then add multiplicand when the bit is set
  always_comb begin
    dbl   = {1'b0, pr_q} + {1'b0, pr_q};
    dbl_r = (dbl >= {1'b0, n_q}) ? VALUE_BITS'(dbl - {1'b0, n_q}) : dbl[VALUE_BITS-1:0];
    sum   = {1'b0, dbl_r} + {1'b0, pa_q};
    sum_r = (sum >= {1'b0, n_q}) ? VALUE_BITS'(sum - {1'b0, n_q}) : sum[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      r2ok_q <= 1'b0;
    end else begin
      if (cmd_i.mul_start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(VALUE_BITS - 1);
      end else if (cmd_i.mul_step) begin
        if (cnt_q == '0) busy_q <= 1'b0;
        else cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.keep_r2) r2ok_q <= (acc_q <= one);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= n_in;
      e_q <= n_in - one;
      sq_q <= b2;
    end
    if (cmd_i.next_base) begin
      e_q   <= n_q - one;
      acc_q <= one;
      sq_q  <= b3;
    end
    if (cmd_i.load) begin
      acc_q <= one;
    end
    if (cmd_i.exp_shift) e_q <= e_q >> 1;
    if (cmd_i.mul_start) begin
      pa_q <= cmd_i.mul_sq ? sq_q : acc_q;
      pb_q <= sq_q;
      pr_q <= '0;
    end else if (cmd_i.mul_step) begin
      pr_q <= pb_q[VALUE_BITS-1] ? sum_r : dbl_r;
      pb_q <= pb_q << 1;
    end
    if (cmd_i.mul_store) begin
      if (cmd_i.mul_sq) sq_q <= pr_q;
      else acc_q <= pr_q;
    end
  end

  assign sts_o.mul_done = !busy_q;
  assign sts_o.exp_zero = (e_q == '0);
  assign sts_o.exp_lsb  = e_q[0];
  assign sts_o.small_n  = (n_q <= one);
  assign sts_o.verdict  = r2ok_q && (acc_q <= one) && (n_q > one);

endmodule

// ----- src/fptb_ctrl.sv -----
// Controller: sequences exponent bits and multiplies for both bases.
module fptb_ctrl import fptb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      probable_prime_o,
  input  fptb_sts_t sts_i,
  output fptb_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       base3_q, base3_d, sq_q, sq_d, res_q, res_d;

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_OUT);
  assign probable_prime_o = res_q;

  always_comb begin
    state_d = state_q;
    base3_d = base3_q;
    sq_d    = sq_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.mul_sq = sq_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          base3_d    = 1'b0;
          state_d    = S_INIT;
        end
      end
      S_INIT: begin
        // drop candidates zero and one straight to the result
        if (sts_i.small_n) begin
          res_d   = 1'b0;
          state_d = S_OUT;
        end else begin
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (sts_i.exp_zero) begin
          state_d = S_DONE;
        end else begin
          sq_d            = !sts_i.exp_lsb;
          cmd_o.mul_sq    = !sts_i.exp_lsb;
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_store = 1'b1;
          if (sq_q) begin
            // square stored: advance to the next exponent bit
            cmd_o.exp_shift = 1'b1;
            state_d         = S_BIT;
          end else begin
            state_d = S_SQ;
          end
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_SQ: begin
        // acc product stored: square for the same bit
        cmd_o.mul_sq    = 1'b1;
        cmd_o.mul_start = 1'b1;
        sq_d            = 1'b1;
        state_d         = S_MUL;
      end
      S_DONE: begin
        if (!base3_q) begin
          cmd_o.keep_r2   = 1'b1;
          cmd_o.next_base = 1'b1;
          base3_d         = 1'b1;
          state_d         = S_BIT;
        end else begin
          res_d   = sts_i.verdict;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base3_q <= 1'b0;
      sq_q    <= 1'b1;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      base3_q <= base3_d;
      sq_q    <= sq_d;
      res_q   <= res_d;
    end
  end

endmodule

// ----- src/fermat_prime_test_bases_2_3_core.sv -----
// Fermat probable-prime test with bases 2 and 3: one verdict per candidate.
// Each exponent bit takes one modular multiply (the square), or two when the
// bit is set (acc times sq, then the square); both bases run in turn.
// One candidate at a time; candidates 0 and 1 answer without any multiply.
// Reset (rst_ni, asynchronous, active low) returns the controller to idle.
module fermat_prime_test_bases_2_3_core import fptb_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [62:0] candidate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        probable_prime_o
);

  fptb_cmd_t cmd;
  fptb_sts_t sts;

  fptb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .probable_prime_o, .sts_i(sts), .cmd_o(cmd)
  );

  fptb_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .candidate_i, .cmd_i(cmd), .sts_o(sts)
  );

endmodule
